FILE: rtl/i2cee_pkg.sv
// shared widths, codes and reset values for the i2c eeprom byte access master
`default_nettype none

package i2cee_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned PHASE_LEN_W = 16;
   localparam int unsigned WAIT_LEN_W = 20;
   localparam int unsigned DEV_ADDR_W = 7;
   localparam int unsigned POLL_W = 8;
   localparam int unsigned BYTE_W = 8;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PHASE_TICKS  = 3'd0,
      CSR_START_STOP_TICKS = 3'd1,
      CSR_DEVICE_ADDRESS   = 3'd2,
      CSR_ACK_POLL_LIMIT   = 3'd3,
      CSR_WRITE_WAIT_TICKS = 3'd4
   } csr_index_type;

   localparam logic [PHASE_LEN_W-1:0] BIT_PHASE_TICKS_RST = 16'd20;
   localparam logic [PHASE_LEN_W-1:0] START_STOP_TICKS_RST = 16'd50;
   localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RST = 7'd80;
   localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;
   localparam logic [WAIT_LEN_W-1:0] WRITE_WAIT_TICKS_RST = 20'd1000000;

endpackage

`default_nettype wire

FILE: rtl/i2c_eeprom_byte_access_master.sv
// top level: tick-driven i2c master for single-byte eeprom reads and writes
`default_nettype none

// Each request beat is one timing tick of the bus sequencer and yields exactly one
// response beat with the bus line levels and status for that tick. A beat can be
// taken every clock cycle: the tick's sequencer step is a single pass of logic
// between the state registers and the response register, and a new request is
// accepted while the previous response is being taken. Opcode read or write starts
// an access only while idle and takes effect on the same tick; commands given
// while busy act as plain ticks. An acknowledge timeout ends the access with a
// stop and sets ack_error. Configuration must be written while idle; not enforced.
module i2c_eeprom_byte_access_master (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // opcode[1:0], mem_address[9:2], write_data[17:10], sda_in[18], zero fill
   input  wire logic [i2cee_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // scl[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
   // read_data[12:5], ack_error[13], zero fill
   output logic [i2cee_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [i2cee_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [i2cee_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import i2cee_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_HI, PH_ST_LO, PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW,
      PH_ACK_SETUP, PH_ACK_HIGH, PH_ACK_POLL, PH_RX_LOW, PH_RX_HIGH,
      PH_NACK_LOW, PH_NACK_HIGH, PH_SP_LO, PH_SP_HI, PH_WAIT
   } phase_type;

   // configuration
   logic [PHASE_LEN_W-1:0] bit_ticks_ff, ss_ticks_ff;
   logic [DEV_ADDR_W-1:0]  dev_addr_ff;
   logic [POLL_W-1:0]      poll_limit_ff;
   logic [WAIT_LEN_W-1:0]  wait_ticks_ff;

   // sequencer state
   phase_type             phase_ff, phase_in;
   logic [WAIT_LEN_W-1:0] delay_ff, delay_in;
   logic [3:0]            bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0]     shift_ff, shift_in;
   logic [POLL_W-1:0]     poll_ff, poll_in;
   logic                  is_write_ff, is_write_in;
   logic [BYTE_W-1:0]     addr_ff, addr_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [BYTE_W-1:0]     rx_byte_ff, rx_byte_in;
   logic [1:0]            step_ff, step_in;
   logic                  error_ff, error_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   opcode_type            op;
   logic                  sda_in;
   logic                  start;
   phase_type             ph;
   logic [WAIT_LEN_W-1:0] dc, len, len_eff, dc_inc;
   logic                  over;
   logic                  scl, sdo, en, busy, done;
   logic                  accept;

   assign op = opcode_type'(req_tdata[1:0]);
   assign sda_in = req_tdata[18];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      start = (phase_ff == PH_IDLE) && (op == OP_READ || op == OP_WRITE);
      ph = start ? PH_ST_HI : phase_ff;
      dc = start ? '0 : delay_ff;
      is_write_in = start ? (op == OP_WRITE) : is_write_ff;
      addr_in = start ? req_tdata[9:2] : addr_ff;
      data_in = start ? req_tdata[17:10] : data_ff;
      error_in = start ? 1'b0 : error_ff;
      step_in = start ? 2'd0 : step_ff;
      busy = (ph != PH_IDLE);

      case (ph)
         PH_ST_HI, PH_ST_LO, PH_SP_LO, PH_SP_HI: len = {4'd0, ss_ticks_ff};
         PH_WAIT: len = wait_ticks_ff;
         default: len = {4'd0, bit_ticks_ff};
      endcase
      len_eff = (len == '0) ? WAIT_LEN_W'(1) : len;
      dc_inc = dc + WAIT_LEN_W'(1);
      over = (dc_inc >= len_eff);

      phase_in = ph;
      delay_in = dc;
      bit_cnt_in = bit_cnt_ff;
      shift_in = shift_ff;
      poll_in = poll_ff;
      rx_byte_in = rx_byte_ff;
      scl = 1'b1;
      sdo = 1'b1;
      en = 1'b0;

      unique case (ph)
         PH_IDLE: begin
         end
         PH_ST_HI: begin
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_ST_LO;
         end
         PH_ST_LO: begin
            sdo = 1'b0;
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) begin
               shift_in = {dev_addr_ff, (step_in == 2'd2)};
               bit_cnt_in = '0;
               phase_in = PH_TX_SETUP;
            end
         end
         PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW: begin
            scl = (ph == PH_TX_HIGH);
            sdo = shift_ff[BYTE_W-1];
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) begin
               if (ph == PH_TX_SETUP) phase_in = PH_TX_HIGH;
               else if (ph == PH_TX_HIGH) phase_in = PH_TX_LOW;
               else begin
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff + 4'd1;
                  if (bit_cnt_in >= 4'd8) begin
                     poll_in = '0;
                     phase_in = PH_ACK_SETUP;
                  end else begin
                     phase_in = PH_TX_SETUP;
                  end
               end
            end
         end
         PH_ACK_SETUP: begin
            scl = 1'b0;
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_ACK_HIGH;
         end
         PH_ACK_HIGH: begin
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_ACK_POLL;
         end
         PH_ACK_POLL: begin
            delay_in = '0;
            if (!sda_in) begin
               if (step_in == 2'd0) begin
                  step_in = 2'd1;
                  shift_in = addr_in;
                  bit_cnt_in = '0;
                  phase_in = PH_TX_SETUP;
               end else if (is_write_in) begin
                  if (step_in == 2'd1) begin
                     step_in = 2'd2;
                     shift_in = data_in;
                     bit_cnt_in = '0;
                     phase_in = PH_TX_SETUP;
                  end else begin
                     phase_in = PH_SP_LO;
                  end
               end else if (step_in == 2'd1) begin
                  step_in = 2'd2;
                  phase_in = PH_ST_HI;
               end else begin
                  bit_cnt_in = '0;
                  shift_in = '0;
                  phase_in = PH_RX_LOW;
               end
            end else if (poll_ff >= poll_limit_ff) begin
               error_in = 1'b1;
               phase_in = PH_SP_LO;
            end else begin
               poll_in = poll_ff + POLL_W'(1);
            end
         end
         PH_RX_LOW: begin
            scl = 1'b0;
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_RX_HIGH;
         end
         PH_RX_HIGH: begin
            if (dc == '0) shift_in = {shift_ff[BYTE_W-2:0], sda_in};
            delay_in = over ? '0 : dc_inc;
            if (over) begin
               bit_cnt_in = bit_cnt_ff + 4'd1;
               if (bit_cnt_in >= 4'd8) begin
                  rx_byte_in = shift_in;
                  phase_in = PH_NACK_LOW;
               end else begin
                  phase_in = PH_RX_LOW;
               end
            end
         end
         PH_NACK_LOW, PH_NACK_HIGH: begin
            scl = (ph == PH_NACK_HIGH);
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = (ph == PH_NACK_LOW) ? PH_NACK_HIGH : PH_SP_LO;
         end
         PH_SP_LO: begin
            scl = 1'b0;
            sdo = 1'b0;
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_SP_HI;
         end
         PH_SP_HI: begin
            en = 1'b1;
            delay_in = over ? '0 : dc_inc;
            if (over) begin
               phase_in = (is_write_in && !error_in && wait_ticks_ff != '0) ?
                          PH_WAIT : PH_IDLE;
            end
         end
         PH_WAIT: begin
            delay_in = over ? '0 : dc_inc;
            if (over) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
            delay_in = '0;
         end
      endcase

      done = busy && (phase_in == PH_IDLE);
      if (!en) sdo = 1'b1;
      rsp_data_in = {2'b00, error_in, rx_byte_in, done, busy, en, sdo, scl};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_PHASE_TICKS_RST;
         ss_ticks_ff <= START_STOP_TICKS_RST;
         dev_addr_ff <= DEVICE_ADDRESS_RST;
         poll_limit_ff <= ACK_POLL_LIMIT_RST;
         wait_ticks_ff <= WRITE_WAIT_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_PHASE_TICKS:  bit_ticks_ff <= csr_wdata[PHASE_LEN_W-1:0];
            CSR_START_STOP_TICKS: ss_ticks_ff <= csr_wdata[PHASE_LEN_W-1:0];
            CSR_DEVICE_ADDRESS:   dev_addr_ff <= csr_wdata[DEV_ADDR_W-1:0];
            CSR_ACK_POLL_LIMIT:   poll_limit_ff <= csr_wdata[POLL_W-1:0];
            CSR_WRITE_WAIT_TICKS: wait_ticks_ff <= csr_wdata[WAIT_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         bit_cnt_ff <= '0;
         shift_ff <= '0;
         poll_ff <= '0;
         is_write_ff <= 1'b0;
         addr_ff <= '0;
         data_ff <= '0;
         rx_byte_ff <= '0;
         step_ff <= '0;
         error_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff <= shift_in;
         poll_ff <= poll_in;
         is_write_ff <= is_write_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         rx_byte_ff <= rx_byte_in;
         step_ff <= step_in;
         error_ff <= error_in;
         rsp_valid_ff <= 1'b1;
         rsp_data_ff <= rsp_data_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: dv/i2c_eeprom_byte_access_master_test.sv
// testbench for the i2c eeprom byte access master: tick stimulus checked against a bus predictor
`timescale 1ns / 100ps

module i2c_eeprom_byte_access_master_test;
   import i2cee_pkg::*;

   localparam logic [1:0] OP_ILLEGAL = 2'd3;
   localparam int unsigned TICK_TARGET = 1950;
   localparam int unsigned QUIET_TAIL = 300;
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned STALL_LIMIT = 3000;

   // request beat fields, lowest bit last
   typedef struct packed {
      logic       sda;
      logic [7:0] wdata;
      logic [7:0] maddr;
      logic [1:0] op;
   } tick_type;

   // response beat fields, lowest bit last
   typedef struct packed {
      logic       ack_error;
      logic [7:0] read_data;
      logic       done;
      logic       busy;
      logic       sda_en;
      logic       sda_out;
      logic       scl;
   } bus_levels_type;

   typedef struct packed {
      tick_type       stim;
      logic           check;
      bus_levels_type levels;
   } directed_row_type;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_START_HI, SEQ_START_LO, SEQ_TX_SETUP, SEQ_TX_HI, SEQ_TX_LO,
      SEQ_ACK_SETUP, SEQ_ACK_HI, SEQ_ACK_WAIT, SEQ_RX_LO, SEQ_RX_HI, SEQ_NACK_LO,
      SEQ_NACK_HI, SEQ_STOP_LO, SEQ_STOP_HI, SEQ_WRITE_WAIT
   } seq_state_type;

   localparam bus_levels_type IDLE_LEVELS = '{ack_error: 1'b0, read_data: 8'h00, done: 1'b0,
                                          busy: 1'b0, sda_en: 1'b0, sda_out: 1'b1, scl: 1'b1};
   localparam bus_levels_type START_LEVELS = '{ack_error: 1'b0, read_data: 8'h00, done: 1'b0,
                                           busy: 1'b1, sda_en: 1'b1, sda_out: 1'b1, scl: 1'b1};

   localparam directed_row_type DIRECTED_ROWS [6] = '{
      '{'{1'b0, 8'h00, 8'h00, OP_TICK},    1'b1, IDLE_LEVELS},
      '{'{1'b1, 8'hFF, 8'hFF, OP_ILLEGAL}, 1'b1, IDLE_LEVELS},
      '{'{1'b1, 8'hFF, 8'hFF, OP_TICK},    1'b1, IDLE_LEVELS},
      '{'{1'b0, 8'h00, 8'hFF, OP_WRITE},   1'b1, START_LEVELS},
      '{'{1'b1, 8'hFF, 8'h00, OP_READ},    1'b1, START_LEVELS},
      '{'{1'b0, 8'h5A, 8'hA5, OP_ILLEGAL}, 1'b1, START_LEVELS}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_BIT_PHASE_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // bus sequencer copy
   int unsigned cfg_bit_len = BIT_PHASE_TICKS_RST;
   int unsigned cfg_edge_len = START_STOP_TICKS_RST;
   logic [6:0] cfg_dev = DEVICE_ADDRESS_RST;
   logic [7:0] cfg_poll_limit = ACK_POLL_LIMIT_RST;
   int unsigned cfg_wait_len = WRITE_WAIT_TICKS_RST;
   seq_state_type seq = SEQ_IDLE;
   int unsigned tick_cnt = 0;
   int unsigned bits_done = 0;
   int unsigned byte_idx = 0;
   logic [7:0] shifter = '0;
   logic [7:0] polls = '0;
   logic wr_access = 1'b0;
   logic [7:0] addr_hold = '0;
   logic [7:0] data_hold = '0;
   logic [7:0] rx_byte = '0;
   logic timed_out = 1'b0;

   bus_levels_type levels_q [$];
   int unsigned req_beats = 0;
   int unsigned ticks_sent = 0;
   int unsigned quiet_from = 32'hFFFF_FFFF;
   int unsigned idle_cycles = 0;
   int errors = 0;
   bit gaps_on = 1'b0;
   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;

   i2c_eeprom_byte_access_master i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit phase_elapsed(input int unsigned len);
      int unsigned n;
      n = (len == 0) ? 1 : len;
      tick_cnt++;
      if (tick_cnt >= n) begin
         tick_cnt = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void load_tx(input logic [7:0] b);
      shifter = b;
      bits_done = 0;
      seq = SEQ_TX_SETUP;
   endfunction

   function automatic bus_levels_type bus_tick(input tick_type t);
      bus_levels_type o;
      logic drive;
      o = '0;
      o.scl = 1'b1;
      o.sda_out = 1'b1;
      drive = 1'b0;
      if (seq == SEQ_IDLE && (t.op == OP_READ || t.op == OP_WRITE)) begin
         wr_access = (t.op == OP_WRITE);
         addr_hold = t.maddr;
         data_hold = t.wdata;
         timed_out = 1'b0;
         byte_idx = 0;
         tick_cnt = 0;
         seq = SEQ_START_HI;
      end
      o.busy = (seq != SEQ_IDLE);
      case (seq)
         SEQ_START_HI: begin
            drive = 1'b1;
            if (phase_elapsed(cfg_edge_len)) seq = SEQ_START_LO;
         end
         SEQ_START_LO: begin
            drive = 1'b1;
            o.sda_out = 1'b0;
            if (phase_elapsed(cfg_edge_len)) load_tx({cfg_dev, (byte_idx == 2)});
         end
         SEQ_TX_SETUP, SEQ_TX_HI, SEQ_TX_LO: begin
            drive = 1'b1;
            o.scl = (seq == SEQ_TX_HI);
            o.sda_out = shifter[7];
            if (phase_elapsed(cfg_bit_len)) begin
               if (seq == SEQ_TX_SETUP) seq = SEQ_TX_HI;
               else if (seq == SEQ_TX_HI) seq = SEQ_TX_LO;
               else begin
                  shifter = shifter << 1;
                  bits_done++;
                  if (bits_done >= 8) begin
                     polls = '0;
                     seq = SEQ_ACK_SETUP;
                  end else seq = SEQ_TX_SETUP;
               end
            end
         end
         SEQ_ACK_SETUP: begin
            o.scl = 1'b0;
            if (phase_elapsed(cfg_bit_len)) seq = SEQ_ACK_HI;
         end
         SEQ_ACK_HI: begin
            if (phase_elapsed(cfg_bit_len)) seq = SEQ_ACK_WAIT;
         end
         SEQ_ACK_WAIT: begin
            tick_cnt = 0;
            if (!t.sda) begin
               if (byte_idx == 0) begin
                  byte_idx = 1;
                  load_tx(addr_hold);
               end else if (wr_access) begin
                  if (byte_idx == 1) begin
                     byte_idx = 2;
                     load_tx(data_hold);
                  end else seq = SEQ_STOP_LO;
               end else if (byte_idx == 1) begin
                  byte_idx = 2;
                  seq = SEQ_START_HI;
               end else begin
                  bits_done = 0;
                  shifter = '0;
                  seq = SEQ_RX_LO;
               end
            end else if (polls >= cfg_poll_limit) begin
               timed_out = 1'b1;
               seq = SEQ_STOP_LO;
            end else polls++;
         end
         SEQ_RX_LO: begin
            o.scl = 1'b0;
            if (phase_elapsed(cfg_bit_len)) seq = SEQ_RX_HI;
         end
         SEQ_RX_HI: begin
            if (tick_cnt == 0) shifter = {shifter[6:0], t.sda};
            if (phase_elapsed(cfg_bit_len)) begin
               bits_done++;
               if (bits_done >= 8) begin
                  rx_byte = shifter;
                  seq = SEQ_NACK_LO;
               end else seq = SEQ_RX_LO;
            end
         end
         SEQ_NACK_LO, SEQ_NACK_HI: begin
            drive = 1'b1;
            o.scl = (seq == SEQ_NACK_HI);
            if (phase_elapsed(cfg_bit_len))
               seq = (seq == SEQ_NACK_LO) ? SEQ_NACK_HI : SEQ_STOP_LO;
         end
         SEQ_STOP_LO: begin
            drive = 1'b1;
            o.scl = 1'b0;
            o.sda_out = 1'b0;
            if (phase_elapsed(cfg_edge_len)) seq = SEQ_STOP_HI;
         end
         SEQ_STOP_HI: begin
            drive = 1'b1;
            if (phase_elapsed(cfg_edge_len))
               seq = (wr_access && !timed_out && cfg_wait_len != 0) ? SEQ_WRITE_WAIT : SEQ_IDLE;
         end
         SEQ_WRITE_WAIT: begin
            if (phase_elapsed(cfg_wait_len)) seq = SEQ_IDLE;
         end
         default: ;
      endcase
      o.done = o.busy && (seq == SEQ_IDLE);
      o.sda_en = drive;
      if (!drive) o.sda_out = 1'b1;
      o.read_data = rx_byte;
      o.ack_error = timed_out;
      return o;
   endfunction

   task automatic drive_tick(input tick_type t);
      int unsigned seen;
      if (ticks_sent >= quiet_from) quiet = 1'b1;
      if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      seen = req_beats;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(t);
      @(negedge clock);
      while (req_beats == seen) @(negedge clock);
      ticks_sent++;
   endtask

   task automatic offer_tick(input tick_type t);
      levels_q.push_back(bus_tick(t));
      drive_tick(t);
   endtask

   function automatic tick_type noise_tick();
      tick_type t;
      t.op = OP_TICK;
      t.maddr = 8'($urandom);
      t.wdata = 8'($urandom);
      t.sda = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // run ticks until the sequencer is back to idle; a mute slave never acknowledges
   task automatic finish_access(input bit mute);
      tick_type t;
      int unsigned ack_delay;
      int unsigned dead_step;
      dead_step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
      ack_delay = 0;
      while (seq != SEQ_IDLE) begin
         t = noise_tick();
         if ($urandom_range(0, 15) == 0) t.op = 2'($urandom_range(1, 3));
         if (seq == SEQ_ACK_SETUP) begin
            ack_delay = $urandom_range(0, 3);
            if (ack_delay > cfg_poll_limit) ack_delay = cfg_poll_limit;
         end
         if (seq == SEQ_ACK_WAIT)
            t.sda = mute || (byte_idx == dead_step) || (polls < ack_delay);
         offer_tick(t);
      end
   endtask

   task automatic csr_beat(input csr_index_type idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock);
   endtask

   task automatic program_regs(input int unsigned bit_len, input int unsigned edge_len,
                               input logic [6:0] dev, input logic [7:0] poll_lim,
                               input int unsigned wait_len);
      csr_beat(CSR_BIT_PHASE_TICKS, bit_len);
      csr_beat(CSR_START_STOP_TICKS, edge_len);
      csr_beat(CSR_DEVICE_ADDRESS, dev);
      csr_beat(CSR_ACK_POLL_LIMIT, poll_lim);
      csr_beat(CSR_WRITE_WAIT_TICKS, wait_len);
      csr_we <= 1'b0;
      cfg_bit_len = bit_len & 32'hFFFF;
      cfg_edge_len = edge_len & 32'hFFFF;
      cfg_dev = dev;
      cfg_poll_limit = poll_lim;
      cfg_wait_len = wait_len & 32'hF_FFFF;
   endtask

   // stimulus
   initial begin
      tick_type t;
      int unsigned phase_no;
      int unsigned random_end;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration, then a write that times out on the device byte
      foreach (DIRECTED_ROWS[i]) begin
         t = DIRECTED_ROWS[i].stim;
         levels_q.push_back(DIRECTED_ROWS[i].check ? DIRECTED_ROWS[i].levels : bus_tick(t));
         if (DIRECTED_ROWS[i].check) void'(bus_tick(t));
         drive_tick(t);
      end
      finish_access(1'b1);

      random_end = TICK_TARGET;
      quiet_from = random_end - QUIET_TAIL;
      phase_no = 0;
      while (ticks_sent < random_end) begin
         req_tvalid <= 1'b0;
         while (levels_q.size() != 0) @(negedge clock);
         gaps_on = ($urandom_range(0, 2) != 0);
         case (phase_no)
            1: program_regs(0, 0, 7'h00, 8'h00, 0);
            2: program_regs(16'hFFFF, 16'hFFFF, 7'h7F, 8'hFF, 20'hF_FFFF);
            3: program_regs(1, 1, 7'h7F, 8'hFF, 3);
            default: program_regs(($urandom_range(0, 5) == 0) ? $urandom_range(3, 8)
                                                                : $urandom_range(0, 2),
                                  $urandom_range(0, 3), 7'($urandom),
                                  8'($urandom_range(0, 6)),
                                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60));
         endcase
         if (phase_no == 0) hold_rsp = 1'b1;
         if (phase_no == 2) begin
            // slow settings: idle ticks only
            repeat (8) begin
               t = noise_tick();
               if ($urandom_range(0, 1)) t.op = OP_ILLEGAL;
               offer_tick(t);
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(0, 3)) begin
                  t = noise_tick();
                  if ($urandom_range(0, 3) == 0) t.op = OP_ILLEGAL;
                  offer_tick(t);
               end
               t = noise_tick();
               t.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
               case ($urandom_range(0, 3))
                  0: t.maddr = 8'h00;
                  1: t.maddr = 8'hFF;
                  default: ;
               endcase
               offer_tick(t);
               finish_access(1'b0);
            end
         end
         phase_no++;
      end

      req_tvalid <= 1'b0;
      while (levels_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   // response side back-pressure
   initial begin
      bit stall_mode;
      stall_mode = 1'b1;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && stall_mode && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) req_beats <= req_beats + 1;
   end

   always @(posedge clock) begin : check_rsp
      bus_levels_type got;
      bus_levels_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(bus_levels_type)-1:0];
         if (levels_q.size() == 0) begin
            $error("response beat with no expected levels pending");
            errors++;
         end else begin
            want = levels_q.pop_front();
            if (got.scl !== want.scl) begin
               $error("scl: expected %0d, got %0d", want.scl, got.scl);
               errors++;
            end
            if (got.sda_out !== want.sda_out) begin
               $error("sda_out: expected %0d, got %0d", want.sda_out, got.sda_out);
               errors++;
            end
            if (got.sda_en !== want.sda_en) begin
               $error("sda_enable: expected %0d, got %0d", want.sda_en, got.sda_en);
               errors++;
            end
            if (got.busy !== want.busy) begin
               $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
               errors++;
            end
            if (got.done !== want.done) begin
               $error("done_res: expected %0d, got %0d", want.done, got.done);
               errors++;
            end
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
               errors++;
            end
            if (got.ack_error !== want.ack_error) begin
               $error("ack_error: expected %0d, got %0d", want.ack_error, got.ack_error);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
